// File: sv/fcw_pkg.sv
// ---------------------------------------------------------------------------
// fcw_pkg
// Shared types, constants and helpers for the FAT12 cluster chain walker.
// ---------------------------------------------------------------------------
package fcw_pkg;

  localparam int FAT_BYTES          = 4608;
  localparam int SECTOR_BYTES       = 512;
  localparam int DATA_SECTOR_OFFSET = 31;

  localparam int INDEX_W   = 13;
  localparam int BYTE_W    = 8;
  localparam int CLUSTER_W = 12;
  localparam int SIZE_W    = 21;
  localparam int SECTOR_W  = 13;
  localparam int COUNT_W   = 10;
  localparam int FAT_ADDR_W = $clog2(FAT_BYTES);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CLUSTER_W-1:0] CLUSTER_FIRST_USABLE = 12'h002;
  localparam logic [CLUSTER_W-1:0] CLUSTER_LAST_USABLE  = 12'hFEF;
  localparam logic [BYTE_W-1:0]    BYTE_BEYOND_TABLE    = 8'hFF;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_NEXT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CHAIN_END = 2'd1,
    ST_NONE      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_START = 2'd1,
    K_NEXT  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [INDEX_W-1:0]     byte_index;
    logic [BYTE_W-1:0]      byte_value;
    logic                   index_in_table;
    logic [CLUSTER_W-1:0]   first_cluster;
    logic [SIZE_W-1:0]      file_size;
    logic                   size_zero;
    logic                   first_usable;
  } cmd_t;

  function automatic logic cluster_usable(input logic [CLUSTER_W-1:0] c);
    return (c >= CLUSTER_FIRST_USABLE) && (c <= CLUSTER_LAST_USABLE);
  endfunction

endpackage

// File: sv/fcw_ram.sv
// ---------------------------------------------------------------------------
// fcw_ram
// Generic single-port RAM with a registered read.
// ---------------------------------------------------------------------------
module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4608
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fcw_front.sv
// ---------------------------------------------------------------------------
// fcw_front
// Accepts input words, decodes the action and precomputes range checks.
// ---------------------------------------------------------------------------
module fcw_front
  import fcw_pkg::*;
(
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  logic keep;

  assign in_tready = !q_full;

  always_comb begin
    q_cmd.byte_index     = in_tdata[12:0];
    q_cmd.byte_value     = in_tdata[20:13];
    q_cmd.first_cluster  = in_tdata[32:21];
    q_cmd.file_size      = in_tdata[53:33];
    q_cmd.index_in_table = in_tdata[12:0] < INDEX_W'(FAT_BYTES);
    q_cmd.size_zero      = in_tdata[53:33] == '0;
    q_cmd.first_usable   = cluster_usable(in_tdata[32:21]);
    q_cmd.kind           = K_LOAD;
    keep                 = 1'b1;
    case (action_t'(in_tuser))
      ACT_LOAD:  q_cmd.kind = K_LOAD;
      ACT_START: q_cmd.kind = K_START;
      ACT_NEXT:  q_cmd.kind = K_NEXT;
      default:   keep = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && !q_full && keep;

endmodule

// File: sv/fcw_fifo.sv
// ---------------------------------------------------------------------------
// fcw_fifo
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module fcw_fifo
  import fcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

  cmd_t                   entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full    = count_r == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/fcw_back.sv
// ---------------------------------------------------------------------------
// fcw_back
// Executes queued commands: table loads, walk starts and chain steps.
// ---------------------------------------------------------------------------
module fcw_back
  import fcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic [1:0]            out_tuser
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RD0  = 3'b010,
    B_RD1  = 3'b100
  } back_state_t;

  localparam logic [FAT_ADDR_W-1:0] FAT_LIMIT = FAT_ADDR_W'(FAT_BYTES);

  back_state_t           state_r, state_nxt;
  logic [CLUSTER_W-1:0]  cluster_r, cluster_nxt;
  logic [SIZE_W-1:0]     rem_r, rem_nxt;
  logic                  active_r, active_nxt;
  logic [FAT_ADDR_W-1:0] off_r, off_nxt;
  logic                  hi0_r, hi0_nxt;
  logic                  hi1_r, hi1_nxt;
  logic [BYTE_W-1:0]     byte0_r, byte0_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SECTOR_W-1:0]   out_sector_r, out_sector_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic                  out_last_r, out_last_nxt;
  status_t               out_status_r, out_status_nxt;

  logic                  out_free;
  logic                  ram_we;
  logic [FAT_ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0]     ram_rdata;
  logic [FAT_ADDR_W-1:0] off_cur;
  logic [FAT_ADDR_W-1:0] off_next_byte;
  logic [BYTE_W-1:0]     byte1;
  logic [CLUSTER_W-1:0]  entry;
  logic [SIZE_W-1:0]     emit_rem;
  logic [CLUSTER_W-1:0]  emit_cluster;
  logic [COUNT_W-1:0]    emit_count;
  logic [SIZE_W-1:0]     emit_left;

  fcw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FAT_BYTES)
  ) u_fat_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_cmd.byte_value),
    .rdata (ram_rdata)
  );

  assign out_free      = !out_valid_r || out_tready;
  assign off_cur       = FAT_ADDR_W'({1'b0, cluster_r}) + FAT_ADDR_W'(cluster_r >> 1);
  assign off_next_byte = off_r + 1'b1;
  assign byte1         = hi1_r ? BYTE_BEYOND_TABLE : ram_rdata;
  assign entry         = cluster_r[0] ? {byte1, byte0_r[7:4]} : {byte1[3:0], byte0_r};

  // The sector share is computed from either a fresh start or the running count.
  always_comb begin
    emit_rem     = (state_r == B_RD1) ? rem_r : q_cmd.file_size;
    emit_cluster = (state_r == B_RD1) ? entry : q_cmd.first_cluster;
    emit_count   = (emit_rem > SIZE_W'(SECTOR_BYTES)) ? COUNT_W'(SECTOR_BYTES)
                                                      : emit_rem[COUNT_W-1:0];
    emit_left    = emit_rem - SIZE_W'(emit_count);
  end

  always_comb begin
    state_nxt      = state_r;
    cluster_nxt    = cluster_r;
    rem_nxt        = rem_r;
    active_nxt     = active_r;
    off_nxt        = off_r;
    hi0_nxt        = hi0_r;
    hi1_nxt        = hi1_r;
    byte0_nxt      = byte0_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sector_nxt = out_sector_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = off_cur;

    case (state_r)
      B_IDLE: begin
        if (!q_empty && (q_cmd.kind == K_LOAD || out_free)) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            K_LOAD: begin
              ram_addr = q_cmd.byte_index;
              ram_we   = q_cmd.index_in_table;
            end
            K_START: begin
              cluster_nxt    = q_cmd.first_cluster;
              rem_nxt        = q_cmd.file_size;
              active_nxt     = 1'b0;
              out_valid_nxt  = 1'b1;
              out_sector_nxt = '0;
              out_count_nxt  = '0;
              out_last_nxt   = 1'b0;
              if (q_cmd.size_zero) begin
                out_status_nxt = ST_NONE;
              end else if (!q_cmd.first_usable) begin
                out_status_nxt = ST_CHAIN_END;
              end else begin
                rem_nxt        = emit_left;
                active_nxt     = emit_left != '0;
                out_sector_nxt = SECTOR_W'(emit_cluster) + SECTOR_W'(DATA_SECTOR_OFFSET);
                out_count_nxt  = emit_count;
                out_last_nxt   = emit_left == '0;
                out_status_nxt = ST_OK;
              end
            end
            K_NEXT: begin
              if (!active_r) begin
                out_valid_nxt  = 1'b1;
                out_sector_nxt = '0;
                out_count_nxt  = '0;
                out_last_nxt   = 1'b0;
                out_status_nxt = ST_NONE;
              end else begin
                off_nxt   = off_cur;
                hi0_nxt   = off_cur >= FAT_LIMIT;
                state_nxt = B_RD0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_RD0: begin
        ram_addr  = off_next_byte;
        hi1_nxt   = off_next_byte >= FAT_LIMIT;
        byte0_nxt = hi0_r ? BYTE_BEYOND_TABLE : ram_rdata;
        state_nxt = B_RD1;
      end
      B_RD1: begin
        out_valid_nxt = 1'b1;
        state_nxt     = B_IDLE;
        if (!cluster_usable(entry)) begin
          active_nxt     = 1'b0;
          out_sector_nxt = '0;
          out_count_nxt  = '0;
          out_last_nxt   = 1'b0;
          out_status_nxt = ST_CHAIN_END;
        end else begin
          cluster_nxt    = entry;
          rem_nxt        = emit_left;
          active_nxt     = emit_left != '0;
          out_sector_nxt = SECTOR_W'(emit_cluster) + SECTOR_W'(DATA_SECTOR_OFFSET);
          out_count_nxt  = emit_count;
          out_last_nxt   = emit_left == '0;
          out_status_nxt = ST_OK;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cluster_r   <= '0;
      rem_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cluster_r   <= cluster_nxt;
      rem_r       <= rem_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r        <= off_nxt;
    hi0_r        <= hi0_nxt;
    hi1_r        <= hi1_nxt;
    byte0_r      <= byte0_nxt;
    out_sector_r <= out_sector_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_sector_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |->
      (out_sector_r == '0 && out_count_r == '0 && !out_last_r))
    else $error("non-ok result carries nonzero fields");

  a_ok_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK) |->
      (out_count_r != '0 && out_count_r <= COUNT_W'(SECTOR_BYTES)))
    else $error("sector byte count out of range");

  a_read_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RD0) |=> (state_r == B_RD1))
    else $error("second table read skipped");

  a_slot_free_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RD1) |-> !out_valid_r)
    else $error("chain step result would overwrite a pending result");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && !$past(out_valid_r && !out_tready)) |-> !active_r)
    else $error("walk still active after its last sector");
`endif

endmodule

// File: sv/fat12_cluster_chain_walker_core.sv
// ---------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// Loads a FAT12 table byte by byte and walks a file's cluster chain.
//
//   Channel | Direction | tdata (low bit up)                  | tuser / tlast
//   in_     | slave     | byte_index, byte_value,              | tuser: action
//           |           | first_cluster, file_size            |
//   out_    | master    | sector_number, byte_count           | tuser: status,
//           |           |                                     | tlast: last_sector
//
// A load word and a start word are done in the idle state of the back end.
// A next word goes on through B_RD0 and B_RD1: the two packed entry bytes
// are read one after the other through the single port of the table RAM.
// Up to two words wait in the queue; while a result stalls, loads keep draining
// and input closes once the queue is full.
// Reset clears the walk state and the queue; the table contents are not cleared.
// ---------------------------------------------------------------------------
module fat12_cluster_chain_walker_core
  import fcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // byte_index, byte_value, first_cluster, file_size
  input  logic [1:0]            in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sector_number, byte_count
  output logic                  out_tlast,
  output logic [1:0]            out_tuser   // status
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  fcw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  fcw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_cmd),
    .empty (q_empty)
  );

  fcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: bench/fat12_cluster_chain_walker_core_test.sv
// ---------------------------------------------------------------------------
// fat12_cluster_chain_walker_core_test
// Self-checking bench for the FAT12 cluster chain walker. It loads chains
// into the table, walks files of assorted sizes through them, and mixes in
// stray loads, starts, next words and unused-action words. A walk model
// predicts every sector word, and the result stream is compared with it in
// order; both sides of the block idle at random in the first two phases.
// ---------------------------------------------------------------------------
module fat12_cluster_chain_walker_core_test
  import fcw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int TABLE_CLUSTERS = (2 * FAT_BYTES) / 3;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [COUNT_W-1:0]  count;
    logic                last;
    status_t             status;
  } sector_word_t;

  class walk_scoreboard;
    logic [BYTE_W-1:0]    fat [FAT_BYTES];
    bit                   written [FAT_BYTES];
    logic [CLUSTER_W-1:0] cur_cluster;
    logic [SIZE_W-1:0]    remaining;
    bit                   active;
    sector_word_t         expected [$];
    int                   errors;

    function new();
      foreach (fat[i]) begin
        fat[i] = '0;
        written[i] = 1'b0;
      end
      cur_cluster = '0;
      remaining = '0;
      active = 1'b0;
      errors = 0;
    endfunction

    function logic [BYTE_W-1:0] fat_byte(int pos);
      return (pos >= FAT_BYTES) ? 8'hFF : fat[pos];
    endfunction

    function logic [CLUSTER_W-1:0] entry_of(logic [CLUSTER_W-1:0] c);
      int off;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      off = (int'(c) * 3) >> 1;
      b0 = fat_byte(off);
      b1 = fat_byte(off + 1);
      if (!c[0]) return {b1[3:0], b0};
      return {b1, b0[7:4]};
    endfunction

    function bit usable(logic [CLUSTER_W-1:0] c);
      return c >= CLUSTER_FIRST_USABLE && c <= CLUSTER_LAST_USABLE;
    endfunction

    function sector_word_t take_sector();
      sector_word_t w;
      logic [SIZE_W-1:0] cnt;
      cnt = (remaining > SIZE_W'(SECTOR_BYTES)) ? SIZE_W'(SECTOR_BYTES) : remaining;
      remaining = remaining - cnt;
      active = (remaining != 0);
      w.sector = SECTOR_W'(cur_cluster) + SECTOR_W'(DATA_SECTOR_OFFSET);
      w.count = cnt[COUNT_W-1:0];
      w.last = !active;
      w.status = ST_OK;
      return w;
    endfunction

    function void note_input(logic [1:0] act, logic [IN_DATA_W-1:0] data);
      logic [INDEX_W-1:0]   idx;
      logic [CLUSTER_W-1:0] first;
      logic [CLUSTER_W-1:0] nxt;
      logic [SIZE_W-1:0]    size;
      sector_word_t         none;
      idx = data[12:0];
      first = data[32:21];
      size = data[53:33];
      none = '{sector: '0, count: '0, last: 1'b0, status: ST_NONE};
      case (act)
        ACT_LOAD: begin
          if (int'(idx) < FAT_BYTES) begin
            fat[idx] = data[20:13];
            written[idx] = 1'b1;
          end
        end
        ACT_START: begin
          cur_cluster = first;
          remaining = size;
          active = 1'b0;
          if (size == 0) expected.push_back(none);
          else if (!usable(first)) begin
            none.status = ST_CHAIN_END;
            expected.push_back(none);
          end else expected.push_back(take_sector());
        end
        ACT_NEXT: begin
          if (!active) expected.push_back(none);
          else begin
            nxt = entry_of(cur_cluster);
            if (!usable(nxt)) begin
              active = 1'b0;
              none.status = ST_CHAIN_END;
              expected.push_back(none);
            end else begin
              cur_cluster = nxt;
              expected.push_back(take_sector());
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last, logic [1:0] user);
      sector_word_t got;
      sector_word_t want;
      got = '{sector: data[12:0], count: data[22:13], last: last, status: status_t'(user)};
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, actual sector %0d count %0d last %0d status %0d",
                 $time, got.sector, got.count, got.last, got.status);
        return;
      end
      want = expected.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: expected sector %0d count %0d last %0d status %0d, actual %0d %0d %0d %0d",
                 $time, want.sector, want.count, want.last, want.status,
                 got.sector, got.count, got.last, got.status);
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;

  walk_scoreboard book = new();
  walk_scoreboard plan = new();
  int send_idle_pct = 13;
  int recv_stall_pct = 52;
  int n_items = 0;

  fat12_cluster_chain_walker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) book.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) book.check_result(out_tdata, out_tlast, out_tuser);
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input logic [1:0] act, input int idx, input int val,
                           input int first, input int size);
    logic [IN_DATA_W-1:0] data;
    data = {2'b00, SIZE_W'(size), CLUSTER_W'(first), BYTE_W'(val), INDEX_W'(idx)};
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    plan.note_input(act, data);
    plan.expected.delete();
    if (act != ACT_UNUSED && !(act == ACT_LOAD && idx >= FAT_BYTES)) n_items++;
  endtask

  task automatic load_word(input int idx, input int val);
    send_word(ACT_LOAD, idx, val, $urandom_range(4095), $urandom_range(1474560));
  endtask

  task automatic start_word(input int first, input int size);
    send_word(ACT_START, $urandom_range(8191), $urandom_range(255), first, size);
  endtask

  // Table bytes under the current cluster's entry that are not yet written get
  // random contents before the walk reads them, so that no unloaded byte is ever read.
  task automatic next_word();
    int off;
    if (plan.active) begin
      off = (int'(plan.cur_cluster) * 3) >> 1;
      for (int p = off; p <= off + 1; p++) begin
        if (p < FAT_BYTES && !plan.written[p]) load_word(p, $urandom_range(255));
      end
    end
    send_word(ACT_NEXT, $urandom_range(8191), $urandom_range(255),
              $urandom_range(4095), $urandom_range(1474560));
  endtask

  task automatic set_entry(input int c, input logic [CLUSTER_W-1:0] v);
    int off;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    off = (c * 3) >> 1;
    if (c % 2 == 0) begin
      b0 = v[7:0];
      b1 = {plan.fat[off + 1][7:4], v[11:8]};
    end else begin
      b0 = {v[3:0], plan.fat[off][3:0]};
      b1 = v[11:4];
    end
    load_word(off, b0);
    load_word(off + 1, b1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic walk_chain();
    int len;
    int chain [5];
    int size;
    int steps;
    int pick;
    bit dup;
    logic [CLUSTER_W-1:0] tail;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      do begin
        pick = $urandom_range(2, TABLE_CLUSTERS - 1);
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (chain[j] == pick) dup = 1'b1;
      end while (dup);
      chain[i] = pick;
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: tail = 12'hFF8 + CLUSTER_W'($urandom_range(7));
      6: tail = CLUSTER_W'($urandom_range(1));
      7: tail = 12'hFF0 + CLUSTER_W'($urandom_range(7));
      8: tail = CLUSTER_LAST_USABLE;
      default: tail = CLUSTER_W'(chain[0]);
    endcase
    for (int i = 0; i < len; i++)
      set_entry(chain[i], (i == len - 1) ? tail : CLUSTER_W'(chain[i + 1]));
    case ($urandom_range(2))
      0: size = (len - 1) * SECTOR_BYTES + $urandom_range(1, SECTOR_BYTES);
      1: size = len * SECTOR_BYTES + $urandom_range(1, 2000);
      default: size = $urandom_range(1, len * SECTOR_BYTES);
    endcase
    if ($urandom_range(19) == 0) size = $urandom_range(1, 1474560);
    start_word(chain[0], size);
    steps = 0;
    while (plan.active && steps < len + 3) begin
      next_word();
      steps++;
    end
    if ($urandom_range(3) == 0) next_word();
  endtask

  task automatic stray_word();
    case ($urandom_range(4))
      0: load_word($urandom_range(8191), $urandom_range(255));
      1: send_word(ACT_UNUSED, $urandom_range(8191), $urandom_range(255),
                   $urandom_range(4095), $urandom_range(1474560));
      2: start_word($urandom_range(4095),
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1474560));
      default: next_word();
    endcase
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    next_word();
    start_word(0, 100);
    start_word(1, 7);
    start_word(4095, 1474560);
    start_word(5, 0);
    set_entry(2, 12'd3);
    set_entry(3, 12'hFF8);
    start_word(2, 1024);
    next_word();
    next_word();
    start_word(2, 1500);
    next_word();
    next_word();
    set_entry(4, CLUSTER_LAST_USABLE);
    start_word(4, 2000);
    next_word();
    next_word();
    set_entry(TABLE_CLUSTERS - 1, 12'hFF7);
    start_word(TABLE_CLUSTERS - 1, SECTOR_BYTES);
    next_word();
    start_word(TABLE_CLUSTERS - 1, SECTOR_BYTES + 1);
    next_word();
    load_word(8191, 8'hFF);
    load_word(FAT_BYTES - 1, 8'h00);
    send_word(ACT_UNUSED, 0, 0, 0, 0);
    start_word(2, 1);

    while (n_items < 450) begin
      if (n_items >= 150 && send_idle_pct == 13) begin
        drain();
        send_idle_pct = 52;
        recv_stall_pct = 13;
      end else if (n_items >= 300 && send_idle_pct == 52) begin
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(9) < 7) walk_chain();
      else stray_word();
    end

    drain();
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("fat12_cluster_chain_walker_core: match");
    end else begin
      $display("fat12_cluster_chain_walker_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fat12_cluster_chain_walker_core: mismatch");
    $finish;
  end

endmodule
